@@ design/rgb_row_pixel_effects_macros.svh @@
// ----------------------------------------------------------------------------
// rgb_row_pixel_effects_macros.svh
// assertion macros used by the checker of the pixel effects block
// ----------------------------------------------------------------------------
`ifndef RGB_ROW_PIXEL_EFFECTS_MACROS_SVH
`define RGB_ROW_PIXEL_EFFECTS_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define RRPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rrpe check failed");

// next-cycle implication, off while reset is asserted
`define RRPE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rrpe check failed");

// state right after a reset cycle
`define RRPE_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("rrpe reset check failed");

`endif

@@ design/rrpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rrpe_pkg
// types, constants and point-effect function of the rgb row pixel effects block
// ----------------------------------------------------------------------------
package rrpe_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 8;
    localparam int COL_W    = 7;
    localparam int EN_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

    // divide by three: floor(x * 683 / 2048) is exact for x below 768
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EFFECTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDE = 2'd2;

    // effect enable bit positions
    localparam int EN_GREY     = 0;
    localparam int EN_MIRROR   = 1;
    localparam int EN_NEG_R    = 2;
    localparam int EN_NEG_G    = 3;
    localparam int EN_NEG_B    = 4;
    localparam int EN_ZERO_R   = 5;
    localparam int EN_ZERO_G   = 6;
    localparam int EN_ZERO_B   = 7;
    localparam int EN_CONTRAST = 8;

    // queue depth between front and back
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        t_pixel             px;
        logic [COL_W-1:0]   col;
        logic               last;
        logic               mirror;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SEND
    } t_bstate;

    // negate, zero, then contrast on one sample
    function automatic logic [SAMPLE_W-1:0] point_fx(
        input logic [SAMPLE_W-1:0] s,
        input logic                neg,
        input logic                zero,
        input logic                con,
        input logic [SAMPLE_W-1:0] maxv
    );
        logic [SAMPLE_W-1:0] v;
        v = neg ? (SAMPLE_MAX - s) : s;
        if (zero) v = '0;
        if (con) v = (v > (maxv >> 1)) ? maxv : '0;
        return v;
    endfunction

endpackage

@@ design/rrpe_front.sv @@
// ----------------------------------------------------------------------------
// rrpe_front
// config registers, column tracking and point effects; pushes commands to queue
// ----------------------------------------------------------------------------
module rrpe_front import rrpe_pkg::*; #(
    parameter int MAX_ROW_PIXELS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [EN_W-1:0]      i_cfg_data,
    input  logic                 i_s_valid,
    output logic                 o_s_ready,
    input  t_pixel               i_px,
    output logic                 o_push,
    input  logic                 i_q_ready,
    output t_cmd                 o_cmd
);

    logic [EN_W-1:0]     r_effects;
    logic [SAMPLE_W-1:0] r_max_value;
    logic [COL_W-1:0]    r_row_width;
    logic [COL_W-1:0]    r_col;

    logic                r_s_valid;
    t_pixel              r_s_px;
    logic                r_s_grey;
    logic [COL_W-1:0]    r_s_col;
    logic                r_s_last;
    logic                r_s_mirror;

    logic                accept;
    logic [COL_W-1:0]    w_eff;
    logic                last;
    t_pixel              fx_px;
    logic [9:0]          sum;
    logic [19:0]         prod;
    logic [SAMPLE_W-1:0] avg;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effects   <= '0;
            r_max_value <= SAMPLE_MAX;
            r_row_width <= COL_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EFFECTS:  r_effects   <= i_cfg_data;
                CFG_MAX_VAL:  r_max_value <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ROW_WIDE: r_row_width <= i_cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // effective row width and end-of-row decision
    always_comb begin
        if (r_row_width == '0)
            w_eff = COL_W'(1);
        else if (r_row_width > COL_W'(MAX_ROW_PIXELS))
            w_eff = COL_W'(MAX_ROW_PIXELS);
        else
            w_eff = r_row_width;
        last = ({1'b0, r_col} + 8'd1) >= {1'b0, w_eff};
    end

    // point effects before greyscale
    always_comb begin
        fx_px.red   = point_fx(i_px.red, r_effects[EN_NEG_R], r_effects[EN_ZERO_R],
                               r_effects[EN_CONTRAST], r_max_value);
        fx_px.green = point_fx(i_px.green, r_effects[EN_NEG_G], r_effects[EN_ZERO_G],
                               r_effects[EN_CONTRAST], r_max_value);
        fx_px.blue  = point_fx(i_px.blue, r_effects[EN_NEG_B], r_effects[EN_ZERO_B],
                               r_effects[EN_CONTRAST], r_max_value);
    end

    assign o_s_ready = !r_s_valid || i_q_ready;
    assign accept    = i_s_valid && o_s_ready;

    // column counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_col <= '0;
        else if (accept)
            r_col <= last ? '0 : r_col + COL_W'(1);
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s_valid <= 1'b0;
        else if (accept)
            r_s_valid <= 1'b1;
        else if (i_q_ready)
            r_s_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_px     <= fx_px;
            r_s_grey   <= r_effects[EN_GREY];
            r_s_col    <= r_col;
            r_s_last   <= last;
            r_s_mirror <= r_effects[EN_MIRROR];
        end
    end

    // greyscale as integer average by reciprocal multiply
    always_comb begin
        sum  = {2'b00, r_s_px.red} + {2'b00, r_s_px.green} + {2'b00, r_s_px.blue};
        prod = {10'd0, sum} * {10'd0, DIV3_MUL};
        avg  = SAMPLE_W'(prod >> DIV3_SHIFT);
    end

    always_comb begin
        o_push       = r_s_valid;
        o_cmd.px     = r_s_grey ? t_pixel'{red: avg, green: avg, blue: avg} : r_s_px;
        o_cmd.col    = r_s_col;
        o_cmd.last   = r_s_last;
        o_cmd.mirror = r_s_mirror;
    end

endmodule

@@ design/rrpe_fifo.sv @@
// ----------------------------------------------------------------------------
// rrpe_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module rrpe_fifo import rrpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_cmd i_data,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_cmd          r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr;
    logic          rd;

    assign o_ready = r_cnt != CW'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && o_ready;
    assign rd      = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (rd) r_rp <= (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

@@ design/rrpe_back.sv @@
// ----------------------------------------------------------------------------
// rrpe_back
// row store, reverse replay of mirrored rows and the output register
// ----------------------------------------------------------------------------
module rrpe_back import rrpe_pkg::*; #(
    parameter int MAX_ROW_PIXELS = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    output logic   o_pop,
    input  t_cmd   i_cmd,
    output logic   o_m_valid,
    input  logic   i_m_ready,
    output t_pixel o_m_px,
    output logic   o_m_last
);

    localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;

    t_pixel        r_mem [MAX_ROW_PIXELS];
    t_pixel        r_rd;
    t_bstate       r_state;
    t_bstate       n_state;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic          r_out_valid;
    t_pixel        r_out_px;
    logic          r_out_last;

    logic          out_free;
    logic          load;
    t_pixel        ld_px;
    logic          ld_last;

    assign out_free = !r_out_valid || i_m_ready;

    // sequencer: direct pass, store only, or reverse replay
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        load    = 1'b0;
        ld_px   = i_cmd.px;
        ld_last = i_cmd.last;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    if (i_cmd.mirror) begin
                        o_pop = 1'b1;
                        if (i_cmd.last) begin
                            n_idx   = i_cmd.col[AW-1:0];
                            n_state = B_READ;
                        end
                    end else if (out_free) begin
                        o_pop = 1'b1;
                        load  = 1'b1;
                    end
                end
            end
            B_READ: begin
                n_state = B_SEND;
            end
            B_SEND: begin
                ld_px   = r_rd;
                ld_last = (r_idx == '0);
                if (out_free) begin
                    load = 1'b1;
                    if (r_idx == '0) begin
                        n_state = B_IDLE;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = B_READ;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= B_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // row store: every popped pixel is written at its column
    always_ff @(posedge i_clk) begin
        if (o_pop) r_mem[i_cmd.col[AW-1:0]] <= i_cmd.px;
        r_rd <= r_mem[r_idx];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (load)
            r_out_valid <= 1'b1;
        else if (i_m_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_px   <= ld_px;
            r_out_last <= ld_last;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_px    = r_out_px;
    assign o_m_last  = r_out_last;

endmodule

@@ design/rgb_row_pixel_effects.sv @@
// ----------------------------------------------------------------------------
// rgb_row_pixel_effects
// rgb point effects with optional per-row mirroring
// ----------------------------------------------------------------------------
//  channel   dir  beat contents (low bits first)
//  s_axis    in   tdata: red_in, green_in, blue_in
//  m_axis    out  tdata: red_out, green_out, blue_out; tlast: row_end
//  cfg       in   i_cfg_index selects effect_enables, max_value, row_width
//
//  without mirroring a pixel passes stage register, queue and output register;
//  one beat a cycle unless the output stalls. with mirroring a row is taken at
//  one pixel a cycle into the store, then replayed pixel by pixel (store read,
//  then output register); input stalls once the 2-entry queue fills in replay.
//  reset is synchronous; the row store is not cleared.
module rgb_row_pixel_effects import rrpe_pkg::*; #(
    parameter int MAX_ROW_PIXELS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [EN_W-1:0]      i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // red_in, green_in, blue_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // red_out, green_out, blue_out
    output logic                 m_axis_tlast    // row_end
);

    t_pixel in_px;
    t_pixel out_px;
    t_cmd   push_cmd;
    t_cmd   pop_cmd;
    logic   push;
    logic   q_ready;
    logic   q_valid;
    logic   pop;

    assign in_px.red   = s_axis_tdata[7:0];
    assign in_px.green = s_axis_tdata[15:8];
    assign in_px.blue  = s_axis_tdata[23:16];

    rrpe_front #(
        .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_px        (in_px),
        .o_push      (push),
        .i_q_ready   (q_ready),
        .o_cmd       (push_cmd)
    );

    rrpe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_data  (push_cmd),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (pop_cmd)
    );

    rrpe_back #(
        .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_pop     (pop),
        .i_cmd     (pop_cmd),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_px    (out_px),
        .o_m_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_px.blue, out_px.green, out_px.red};

endmodule

@@ design/rrpe_checker.sv @@
// ----------------------------------------------------------------------------
// rrpe_checker
// port-level checks of the rgb row pixel effects block
// ----------------------------------------------------------------------------
`include "rgb_row_pixel_effects_macros.svh"

module rrpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled output beat holds
    `RRPE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // after reset: nothing pending, input open
    `RRPE_ASSERT_RST(a_rst_idle, !m_axis_tvalid && s_axis_tready)

    // input side only closes after taking a beat
    `RRPE_ASSERT_IMP(a_ready_fall, $past(i_rst_n) && $fell(s_axis_tready), $past(s_axis_tvalid))

endmodule

bind rgb_row_pixel_effects rrpe_checker u_rrpe_checker (.*);

@@ tb/tb_rgb_row_pixel_effects.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_row_pixel_effects
// self-checking bench for the rgb row pixel effects block
// ----------------------------------------------------------------------------
// pixels are streamed in with random gaps while the output side stalls at
// random. every accepted input beat runs through a behavioral copy of the
// point effects and the row mirror; the expected output beats are queued and
// compared field by field against what the block emits. directed tests cover
// reset defaults, each effect, contrast thresholds, grey rounding, width
// clamping and settings changed in the middle of a row, then random rows
// with random settings make up the bulk of the traffic.
// ----------------------------------------------------------------------------
module tb_rgb_row_pixel_effects;
    import rrpe_pkg::*;

    localparam int ROW_MAX      = 64;
    localparam int TARGET_ITEMS = 470;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 40;

    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [EN_W-1:0] FX_NONE     = '0;
    localparam logic [EN_W-1:0] FX_GREY     = EN_W'(1 << EN_GREY);
    localparam logic [EN_W-1:0] FX_MIRROR   = EN_W'(1 << EN_MIRROR);
    localparam logic [EN_W-1:0] FX_NEG_ALL  = EN_W'((1 << EN_NEG_R) | (1 << EN_NEG_G)
                                                   | (1 << EN_NEG_B));
    localparam logic [EN_W-1:0] FX_ZERO_ALL = EN_W'((1 << EN_ZERO_R) | (1 << EN_ZERO_G)
                                                   | (1 << EN_ZERO_B));
    localparam logic [EN_W-1:0] FX_CONTRAST = EN_W'(1 << EN_CONTRAST);

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } rgb_t;

    typedef struct {
        rgb_t px;
        logic row_end;
    } out_beat_t;

    // dut ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [EN_W-1:0]      i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;   // red_in, green_in, blue_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;         // red_out, green_out, blue_out
    logic                 m_axis_tlast;         // row_end

    // predictor copy of registers and row state
    logic [EN_W-1:0]     cfg_effects = '0;
    logic [SAMPLE_W-1:0] cfg_max     = 8'd255;
    logic [COL_W-1:0]    cfg_width   = 7'd64;
    rgb_t                row_copy [ROW_MAX];
    int                  col_next    = 0;

    out_beat_t pending_pixels [$];
    int        mismatch_count = 0;
    int        items_sent     = 0;

    // pacing state for both sides
    int src_run_left    = 0;
    bit src_quiet       = 1'b0;
    int sink_run_left   = 0;
    bit sink_quiet      = 1'b0;
    int sink_stall_left = 0;

    rgb_row_pixel_effects #(
        .MAX_ROW_PIXELS(ROW_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // contrast snaps a sample to max or zero around half of max
    function automatic logic [SAMPLE_W-1:0] contrast_level(input logic [SAMPLE_W-1:0] s);
        return (s > (cfg_max >> 1)) ? cfg_max : '0;
    endfunction

    // negate, zero, contrast, then grey, with the settings of this moment
    function automatic rgb_t apply_point_effects(input rgb_t p);
        rgb_t       q;
        logic [9:0] sum;
        q = p;
        if (cfg_effects[EN_NEG_R]) q.red   = SAMPLE_MAX - q.red;
        if (cfg_effects[EN_NEG_G]) q.green = SAMPLE_MAX - q.green;
        if (cfg_effects[EN_NEG_B]) q.blue  = SAMPLE_MAX - q.blue;
        if (cfg_effects[EN_ZERO_R]) q.red   = '0;
        if (cfg_effects[EN_ZERO_G]) q.green = '0;
        if (cfg_effects[EN_ZERO_B]) q.blue  = '0;
        if (cfg_effects[EN_CONTRAST]) begin
            q.red   = contrast_level(q.red);
            q.green = contrast_level(q.green);
            q.blue  = contrast_level(q.blue);
        end
        if (cfg_effects[EN_GREY]) begin
            sum     = q.red + q.green + q.blue;
            q.red   = SAMPLE_W'(sum / 3);
            q.green = SAMPLE_W'(sum / 3);
            q.blue  = SAMPLE_W'(sum / 3);
        end
        return q;
    endfunction

    // store the pixel and queue whatever beats it releases
    task automatic predict_pixel(input rgb_t raw);
        rgb_t      px;
        int        w;
        int        c;
        logic      row_done;
        out_beat_t b;
        px = apply_point_effects(raw);
        w  = (cfg_width == 0) ? 1 : ((cfg_width > ROW_MAX) ? ROW_MAX : int'(cfg_width));
        c  = (col_next >= ROW_MAX) ? ROW_MAX - 1 : col_next;
        row_copy[c] = px;
        row_done    = (c + 1 >= w);
        col_next    = row_done ? 0 : c + 1;
        if (cfg_effects[EN_MIRROR]) begin
            if (row_done) begin
                for (int i = c; i >= 0; i--) begin
                    b.px      = row_copy[i];
                    b.row_end = (i == 0);
                    pending_pixels.push_back(b);
                end
            end
        end else begin
            b.px      = px;
            b.row_end = row_done;
            pending_pixels.push_back(b);
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // input beats feed the predictor, output beats are checked in order
    always @(posedge i_clk) begin : check_beats
        out_beat_t want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_pixel(rgb_t'{s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]});
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                report($sformatf("output beat with nothing expected, data %h last %b",
                                 m_axis_tdata, m_axis_tlast));
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.px.red)
                    report($sformatf("red_out got %0d want %0d", m_axis_tdata[7:0],
                                     want.px.red));
                if (m_axis_tdata[15:8] !== want.px.green)
                    report($sformatf("green_out got %0d want %0d", m_axis_tdata[15:8],
                                     want.px.green));
                if (m_axis_tdata[23:16] !== want.px.blue)
                    report($sformatf("blue_out got %0d want %0d", m_axis_tdata[23:16],
                                     want.px.blue));
                if (m_axis_tlast !== want.row_end)
                    report($sformatf("row_end got %b want %b", m_axis_tlast, want.row_end));
            end
        end
    end

    // ------------------------------------------------------------------------
    // pacing
    // ------------------------------------------------------------------------

    // mostly short pauses, now and then a long one
    function automatic int pause_length();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // idle cycles before the next input beat, in quiet or busy stretches
    function automatic int source_gap();
        if (src_run_left == 0) begin
            src_run_left = $urandom_range(5, 40);
            src_quiet    = ($urandom_range(0, 2) == 0);
        end else begin
            src_run_left--;
        end
        if (src_quiet || $urandom_range(0, 1) == 0)
            return 0;
        return pause_length();
    endfunction

    // output back-pressure
    always @(posedge i_clk) begin
        if (sink_run_left == 0) begin
            sink_run_left = $urandom_range(20, 200);
            sink_quiet    = ($urandom_range(0, 2) == 0);
        end else begin
            sink_run_left--;
        end
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!sink_quiet && $urandom_range(0, 3) == 0) begin
            sink_stall_left = pause_length() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one pixel beat, valid stays up when the next beat follows directly
    task automatic send_pixel(input rgb_t p);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.blue, p.green, p.red};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EN_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_EFFECTS:  cfg_effects = val;
            CFG_MAX_VAL:  cfg_max     = val[SAMPLE_W-1:0];
            CFG_ROW_WIDE: cfg_width   = val[COL_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, let the last taken beat be predicted, wait for all expected
    // beats, then let the store writes land
    task automatic settle_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : '0;
        return SAMPLE_W'($urandom_range(0, 255));
    endfunction

    function automatic rgb_t rand_pixel();
        return rgb_t'{rand_sample(), rand_sample(), rand_sample()};
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset settings: no effects, 64 wide, pixels pass straight through
    task automatic test_reset_defaults();
        send_pixel(rgb_t'{8'h00, 8'h00, 8'h00});
        send_pixel(rgb_t'{8'hFF, 8'hFF, 8'hFF});
        send_pixel(rgb_t'{8'hAA, 8'h55, 8'h0F});
        send_pixel(rgb_t'{8'h55, 8'hAA, 8'hF0});
    endtask

    // column already past the new last column, next pixel ends the row
    task automatic test_width_lowered();
        settle_pipeline();
        write_reg(CFG_ROW_WIDE, EN_W'(2));
        send_pixel(rgb_t'{8'h12, 8'h34, 8'h56});
    endtask

    task automatic effect_case(input logic [EN_W-1:0] fx, input logic [SAMPLE_W-1:0] maxv,
                               input rgb_t p);
        settle_pipeline();
        write_reg(CFG_EFFECTS, fx);
        write_reg(CFG_MAX_VAL, EN_W'(maxv));
        send_pixel(p);
    endtask

    // each point effect alone, contrast thresholds, grey rounding, all combined
    task automatic test_point_effects();
        settle_pipeline();
        write_reg(CFG_ROW_WIDE, EN_W'(1));
        write_reg(CFG_SPARE, EN_W'(9'h1FF));
        effect_case(FX_NEG_ALL, 8'd255, rgb_t'{8'h00, 8'hFF, 8'h80});
        effect_case(FX_NEG_ALL, 8'd255, rgb_t'{8'h0F, 8'hF0, 8'h01});
        effect_case(FX_ZERO_ALL, 8'd255, rgb_t'{8'h12, 8'h34, 8'h56});
        effect_case(FX_CONTRAST, 8'd255, rgb_t'{8'd127, 8'd128, 8'd255});
        effect_case(FX_CONTRAST, 8'd0, rgb_t'{8'd0, 8'd1, 8'd255});
        effect_case(FX_CONTRAST, 8'd1, rgb_t'{8'd0, 8'd1, 8'd2});
        effect_case(FX_GREY, 8'd255, rgb_t'{8'hFF, 8'hFF, 8'hFF});
        effect_case(FX_GREY, 8'd255, rgb_t'{8'd1, 8'd1, 8'd0});
        effect_case(FX_GREY, 8'd255, rgb_t'{8'h80, 8'h81, 8'h82});
        effect_case(~(FX_MIRROR), 8'd200, rgb_t'{8'd10, 8'd200, 8'd120});
    endtask

    // width zero, a plain mirrored row, and mirror switched on and off mid-row
    task automatic test_mirror_rows();
        settle_pipeline();
        write_reg(CFG_EFFECTS, FX_MIRROR);
        write_reg(CFG_MAX_VAL, EN_W'(255));
        write_reg(CFG_ROW_WIDE, EN_W'(0));
        send_pixel(rgb_t'{8'h01, 8'h02, 8'h03});
        settle_pipeline();
        write_reg(CFG_ROW_WIDE, EN_W'(4));
        for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
        settle_pipeline();
        write_reg(CFG_EFFECTS, FX_NONE);
        write_reg(CFG_ROW_WIDE, EN_W'(3));
        send_pixel(rand_pixel());
        settle_pipeline();
        write_reg(CFG_EFFECTS, FX_MIRROR | FX_NEG_ALL);
        send_pixel(rand_pixel());
        send_pixel(rand_pixel());
        settle_pipeline();
        send_pixel(rand_pixel());
        settle_pipeline();
        write_reg(CFG_EFFECTS, FX_NONE);
        send_pixel(rand_pixel());
        send_pixel(rand_pixel());
    endtask

    // width above the store size is clamped, one full mirrored row
    task automatic test_widest_row();
        settle_pipeline();
        write_reg(CFG_EFFECTS, FX_MIRROR | FX_NEG_ALL);
        write_reg(CFG_ROW_WIDE, EN_W'(127));
        for (int i = 0; i < ROW_MAX; i++) send_pixel(rand_pixel());
    endtask

    // random settings, mostly whole rows, sometimes a row left unfinished
    task automatic test_random_rows();
        int sel;
        int w;
        int eff_w;
        int count;
        logic [SAMPLE_W-1:0] maxv;
        while (items_sent < TARGET_ITEMS) begin
            settle_pipeline();
            if ($urandom_range(0, 9) < 7)
                write_reg(CFG_EFFECTS, EN_W'($urandom_range(0, 511)));
            if ($urandom_range(0, 9) < 5) begin
                sel  = $urandom_range(0, 5);
                maxv = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd1 : (sel == 2) ? 8'd255
                     : SAMPLE_W'($urandom_range(0, 255));
                write_reg(CFG_MAX_VAL, EN_W'(maxv));
            end
            if ($urandom_range(0, 9) < 7) begin
                sel = $urandom_range(0, 19);
                w   = (sel == 0) ? 0 : (sel == 1) ? 127 : (sel == 2) ? 64
                    : (sel < 5) ? $urandom_range(9, 63) : $urandom_range(1, 8);
                write_reg(CFG_ROW_WIDE, EN_W'(w));
            end
            eff_w = (cfg_width == 0) ? 1 : ((cfg_width > ROW_MAX) ? ROW_MAX : int'(cfg_width));
            count = (eff_w > 8) ? eff_w : eff_w * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
                count = count + $urandom_range(0, eff_w - 1);
            for (int i = 0; i < count; i++) send_pixel(rand_pixel());
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_width_lowered();
        test_point_effects();
        test_mirror_rows();
        test_widest_row();
        test_random_rows();
        settle_pipeline();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_rgb_row_pixel_effects: PASS");
        end else begin
            $display("tb_rgb_row_pixel_effects: FAIL");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(12 * 400000);
        $display("tb_rgb_row_pixel_effects: FAIL");
        $finish;
    end

endmodule
